>>> hdl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window: field
// widths, configuration register map, reset values, command codes and controller states.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Payload field widths, fixed by the channel definition
  localparam int SEQ_FIELD_W  = 8;
  localparam int BASE_FIELD_W = 9;

  // Configuration register widths
  localparam int WIN_W      = 6;
  localparam int PKT_CNT_W  = 9;
  localparam int TIMEOUT_W  = 32;
  localparam int INTERVAL_W = 16;

  // APB port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] REG_PACKET_COUNT  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT       = 2'd2;
  localparam logic [1:0] REG_SEND_INTERVAL = 2'd3;

  // Register reset values
  localparam logic [WIN_W-1:0]      RST_WINDOW_SIZE   = 6'd4;
  localparam logic [PKT_CNT_W-1:0]  RST_PACKET_COUNT  = 9'd0;
  localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT       = 32'd1000;
  localparam logic [INTERVAL_W-1:0] RST_SEND_INTERVAL = 16'd1;

  // Input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEW,
    ST_FLUSH,
    ST_SLIDE,
    ST_NAK
  } state_t;

endpackage

>>> hdl/srsw_in_if.sv
// ----------------------------------------------------------------------------
// srsw_in_if
// Input channel: one beat is a tick or a received acknowledgment.
// ----------------------------------------------------------------------------
interface srsw_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [srsw_pkg::SEQ_FIELD_W-1:0] ack_seq;
  logic                             ack_positive;
  logic                             ack_valid;

  modport source (
    output valid, command, ack_seq, ack_positive, ack_valid,
    input  ready
  );

  modport sink (
    input  valid, command, ack_seq, ack_positive, ack_valid,
    output ready
  );
endinterface

>>> hdl/srsw_out_if.sv
// ----------------------------------------------------------------------------
// srsw_out_if
// Result channel: one beat names one packet to transmit.
// ----------------------------------------------------------------------------
interface srsw_out_if;
  logic                              valid;
  logic                              ready;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]  send_seq;
  logic                              is_retransmit;
  logic                              last;
  logic [srsw_pkg::BASE_FIELD_W-1:0] window_base;
  logic                              transfer_done;

  modport source (
    output valid, send_seq, is_retransmit, last, window_base, transfer_done,
    input  ready
  );

  modport sink (
    input  valid, send_seq, is_retransmit, last, window_base, transfer_done,
    output ready
  );
endinterface

>>> hdl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of a selective-repeat ARQ link. Each input beat is either a
// tick or an acknowledgment; each output beat names a packet to transmit,
// with last set on the final beat caused by an input beat. Per-packet state
// (acknowledged mark and last send time) lives in two synchronous-read
// memories that the controller reads, modifies and writes back. Input beats
// are taken one at a time. A tick runs a timer scan over the sent slots
// inside the window, reading one slot per cycle from both memories while
// the output is not stalled, then a new-send check, then a hand-over of the
// final beat. A positive ACK that moves the base slides it on past every
// further acknowledged slot. A full output register stalls the controller.
// No clearing pass is needed after reset: a slot's mark is initialised when
// the packet is first sent.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
  parameter int BUFFER_DEPTH = 256,
  parameter int WINDOW_MAX   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  srsw_in_if.sink                         in_ch,
  srsw_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [srsw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [srsw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int WIN_W  = srsw_pkg::WIN_W;
  localparam int PC_W   = srsw_pkg::PKT_CNT_W;
  localparam int TO_W   = srsw_pkg::TIMEOUT_W;
  localparam int IV_W   = srsw_pkg::INTERVAL_W;
  localparam int DW     = srsw_pkg::CFG_DATA_W;
  localparam int AW     = srsw_pkg::CFG_ADDR_W;
  localparam int SQO_W  = srsw_pkg::SEQ_FIELD_W;
  localparam int BSO_W  = srsw_pkg::BASE_FIELD_W;
  localparam int IDX_W  = $clog2(BUFFER_DEPTH);
  localparam int SEQ_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int LIM_W  = $clog2(BUFFER_DEPTH + WINDOW_MAX + 1);
  localparam int CMP_W  = (LIM_W > PC_W) ? LIM_W : PC_W;

  localparam logic [WIN_W-1:0] WMAX_V  = WIN_W'(WINDOW_MAX);
  localparam logic [CMP_W-1:0] DEPTH_V = CMP_W'(BUFFER_DEPTH);

  // Configuration registers
  logic [WIN_W-1:0] window_size_r;
  logic [PC_W-1:0]  packet_count_r;
  logic [TO_W-1:0]  timeout_r;
  logic [IV_W-1:0]  interval_r;

  // Control state
  srsw_pkg::state_t state_r, state_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_new_r, next_new_nxt;
  logic [SEQ_W-1:0] i_r, i_nxt;
  logic [TO_W-1:0]  tick_r, tick_nxt;
  logic [TO_W-1:0]  last_new_r, last_new_nxt;

  // Held result, waiting to learn whether it is the final one
  logic             pend_v_r, pend_v_nxt;
  logic [SEQ_W-1:0] pend_seq_r, pend_seq_nxt;
  logic             pend_retx_r, pend_retx_nxt;

  // Output register
  logic             out_valid_r;
  logic [SQO_W-1:0] out_seq_r;
  logic             out_retx_r;
  logic             out_last_r;
  logic [BSO_W-1:0] out_base_r;
  logic             out_done_r;

  // Memories and their ports
  logic             mark_mem [BUFFER_DEPTH];
  logic [TO_W-1:0]  time_mem [BUFFER_DEPTH];
  logic [IDX_W-1:0] rd_addr;
  logic             mark_q;
  logic [TO_W-1:0]  time_q;
  logic             mark_we, mark_wd;
  logic [IDX_W-1:0] mark_wa;
  logic             time_we;
  logic [IDX_W-1:0] time_wa;
  logic [TO_W-1:0]  time_wd;

  // Derived values
  logic [WIN_W-1:0] w_eff;
  logic [CMP_W-1:0] pc_x, cnt_eff, base_x, next_x, i_x, lim_x, ack_x;
  logic [SEQ_W-1:0] base_inc, i_inc;
  logic             in_acc, cfg_we, can_load, blocked;
  logic             scan_in_range, expired, new_ok, ack_ok;
  logic             load_pend, load_last;

  // Effective window and packet count
  always_comb begin
    if (window_size_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_size_r > WMAX_V) begin
      w_eff = WMAX_V;
    end else begin
      w_eff = window_size_r;
    end
    pc_x    = CMP_W'(packet_count_r);
    cnt_eff = (pc_x > DEPTH_V) ? DEPTH_V : pc_x;
  end

  assign base_x   = CMP_W'(base_r);
  assign next_x   = CMP_W'(next_new_r);
  assign i_x      = CMP_W'(i_r);
  assign lim_x    = base_x + CMP_W'(w_eff);
  assign ack_x    = CMP_W'(in_ch.ack_seq);
  assign base_inc = base_r + SEQ_W'(1);
  assign i_inc    = i_r + SEQ_W'(1);

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign can_load = !out_valid_r || out_ch.ready;
  assign blocked  = pend_v_r && !can_load;

  // Per-slot and per-tick decisions
  assign scan_in_range = (i_x < next_x) && (i_x < lim_x);
  assign expired       = !mark_q && ((tick_r - time_q) > timeout_r);
  assign new_ok        = ((tick_r - last_new_r) >= TO_W'(interval_r))
                         && (next_x < lim_x) && (next_x < cnt_eff);
  assign ack_ok        = in_ch.ack_valid && (ack_x >= base_x) && (ack_x < next_x);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srsw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == srsw_pkg::CMD_TICK) begin
            state_nxt = srsw_pkg::ST_SCAN;
          end else if (ack_ok) begin
            if (in_ch.ack_positive) begin
              if (ack_x == base_x) state_nxt = srsw_pkg::ST_SLIDE;
            end else begin
              state_nxt = srsw_pkg::ST_NAK;
            end
          end
        end
      end
      srsw_pkg::ST_SCAN: begin
        if (!scan_in_range) state_nxt = srsw_pkg::ST_NEW;
      end
      srsw_pkg::ST_NEW: begin
        if (!(new_ok && blocked)) state_nxt = srsw_pkg::ST_FLUSH;
      end
      srsw_pkg::ST_FLUSH: begin
        if (!pend_v_r || can_load) state_nxt = srsw_pkg::ST_IDLE;
      end
      srsw_pkg::ST_SLIDE: begin
        if (!((base_x < next_x) && mark_q)) state_nxt = srsw_pkg::ST_IDLE;
      end
      srsw_pkg::ST_NAK: begin
        state_nxt = mark_q ? srsw_pkg::ST_IDLE : srsw_pkg::ST_FLUSH;
      end
      default: state_nxt = srsw_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory ports and result hand-over
  always_comb begin
    base_nxt      = base_r;
    next_new_nxt  = next_new_r;
    i_nxt         = i_r;
    tick_nxt      = tick_r;
    last_new_nxt  = last_new_r;
    pend_v_nxt    = pend_v_r;
    pend_seq_nxt  = pend_seq_r;
    pend_retx_nxt = pend_retx_r;
    load_pend     = 1'b0;
    load_last     = 1'b0;
    rd_addr       = i_r[IDX_W-1:0];
    mark_we       = 1'b0;
    mark_wa       = next_new_r[IDX_W-1:0];
    mark_wd       = 1'b0;
    time_we       = 1'b0;
    time_wa       = i_r[IDX_W-1:0];
    time_wd       = tick_r;
    unique case (state_r)
      srsw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == srsw_pkg::CMD_TICK) begin
            tick_nxt = tick_r + TO_W'(1);
            i_nxt    = base_r;
            rd_addr  = base_r[IDX_W-1:0];
          end else if (ack_ok) begin
            if (in_ch.ack_positive) begin
              mark_we = 1'b1;
              mark_wa = ack_x[IDX_W-1:0];
              mark_wd = 1'b1;
              if (ack_x == base_x) begin
                base_nxt = base_inc;
                rd_addr  = base_inc[IDX_W-1:0];
              end
            end else begin
              rd_addr       = ack_x[IDX_W-1:0];
              pend_seq_nxt  = SEQ_W'(in_ch.ack_seq);
              pend_retx_nxt = 1'b1;
            end
          end
        end
      end
      srsw_pkg::ST_SCAN: begin
        if (scan_in_range) begin
          if (expired) begin
            if (!blocked) begin
              time_we       = 1'b1;
              load_pend     = pend_v_r;
              pend_v_nxt    = 1'b1;
              pend_seq_nxt  = i_r;
              pend_retx_nxt = 1'b1;
              i_nxt         = i_inc;
              rd_addr       = i_inc[IDX_W-1:0];
            end
          end else begin
            i_nxt   = i_inc;
            rd_addr = i_inc[IDX_W-1:0];
          end
        end
      end
      srsw_pkg::ST_NEW: begin
        if (new_ok && !blocked) begin
          time_we       = 1'b1;
          time_wa       = next_new_r[IDX_W-1:0];
          mark_we       = 1'b1;
          load_pend     = pend_v_r;
          pend_v_nxt    = 1'b1;
          pend_seq_nxt  = next_new_r;
          pend_retx_nxt = 1'b0;
          next_new_nxt  = next_new_r + SEQ_W'(1);
          last_new_nxt  = tick_r;
        end
      end
      srsw_pkg::ST_FLUSH: begin
        if (pend_v_r && can_load) begin
          load_pend  = 1'b1;
          load_last  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      srsw_pkg::ST_SLIDE: begin
        if ((base_x < next_x) && mark_q) begin
          base_nxt = base_inc;
          rd_addr  = base_inc[IDX_W-1:0];
        end
      end
      srsw_pkg::ST_NAK: begin
        if (!mark_q) pend_v_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srsw_pkg::ST_IDLE;
      base_r      <= '0;
      next_new_r  <= '0;
      tick_r      <= '0;
      last_new_r  <= '0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_new_r  <= next_new_nxt;
      tick_r      <= tick_nxt;
      last_new_r  <= last_new_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_retx_r <= pend_retx_nxt;
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_pend) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (load_pend) begin
      out_seq_r  <= SQO_W'(pend_seq_r);
      out_retx_r <= pend_retx_r;
      out_last_r <= load_last;
      out_base_r <= BSO_W'(base_r);
      out_done_r <= (base_x >= cnt_eff);
    end
  end

  assign in_ch.ready          = (state_r == srsw_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.send_seq      = out_seq_r;
  assign out_ch.is_retransmit = out_retx_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.window_base   = out_base_r;
  assign out_ch.transfer_done = out_done_r;

  // Acknowledged marks
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_q <= mark_mem[rd_addr];
  end

  // Last send times
  always_ff @(posedge clk) begin
    if (time_we) time_mem[time_wa] <= time_wd;
    time_q <= time_mem[rd_addr];
  end

  // APB register write
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r  <= srsw_pkg::RST_WINDOW_SIZE;
      packet_count_r <= srsw_pkg::RST_PACKET_COUNT;
      timeout_r      <= srsw_pkg::RST_TIMEOUT;
      interval_r     <= srsw_pkg::RST_SEND_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_paddr[AW-1:2])
        srsw_pkg::REG_WINDOW_SIZE:   window_size_r  <= cfg_pwdata[WIN_W-1:0];
        srsw_pkg::REG_PACKET_COUNT:  packet_count_r <= cfg_pwdata[PC_W-1:0];
        srsw_pkg::REG_TIMEOUT:       timeout_r      <= cfg_pwdata[TO_W-1:0];
        srsw_pkg::REG_SEND_INTERVAL: interval_r     <= cfg_pwdata[IV_W-1:0];
      endcase
    end
  end

  // APB register read
  always_comb begin
    unique case (cfg_paddr[AW-1:2])
      srsw_pkg::REG_WINDOW_SIZE:   cfg_prdata = DW'(window_size_r);
      srsw_pkg::REG_PACKET_COUNT:  cfg_prdata = DW'(packet_count_r);
      srsw_pkg::REG_TIMEOUT:       cfg_prdata = DW'(timeout_r);
      srsw_pkg::REG_SEND_INTERVAL: cfg_prdata = DW'(interval_r);
    endcase
  end

  // Checks
  a_base_le_next: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= next_new_r)
    else $error("window base passed next new sequence number");

  a_next_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    next_new_r <= SEQ_W'(BUFFER_DEPTH))
    else $error("next new sequence number beyond buffer depth");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srsw_pkg::ST_IDLE) |-> !pend_v_r)
    else $error("held result left over when idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_pend |-> can_load)
    else $error("output register overwritten while full");

  a_base_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srsw_pkg::ST_SCAN) |=> $stable(base_r))
    else $error("window base moved during timer scan");

endmodule

>>> verif/srsw_send_checker.sv
// ----------------------------------------------------------------------------
// srsw_send_checker
// Watches both channels and the APB port of the sender window. It keeps its
// own copy of the window state and registers, works out the send beats each
// accepted input beat should cause, and compares every output beat against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module srsw_send_checker #(
  parameter int BUFFER_DEPTH = 256,
  parameter int WINDOW_MAX   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  srsw_in_if                                in_mon,
  srsw_out_if                               out_mon,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [srsw_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input  logic                              cfg_pready,
  output int unsigned                       fail_count,
  output int unsigned                       pending,
  output logic [srsw_pkg::BASE_FIELD_W-1:0] model_base,
  output logic [srsw_pkg::BASE_FIELD_W-1:0] model_next
);

  localparam int SQ_W = srsw_pkg::SEQ_FIELD_W;
  localparam int BS_W = srsw_pkg::BASE_FIELD_W;

  typedef struct packed {
    logic [SQ_W-1:0] seq;
    logic            retx;
    logic            last;
    logic [BS_W-1:0] base;
    logic            done;
  } send_beat_t;

  // Predicted send beats, oldest first
  send_beat_t sends_due[$];

  // Register copies
  logic [srsw_pkg::WIN_W-1:0]      win_r;
  logic [srsw_pkg::PKT_CNT_W-1:0]  cnt_r;
  logic [srsw_pkg::TIMEOUT_W-1:0]  tmo_r;
  logic [srsw_pkg::INTERVAL_W-1:0] ivl_r;

  // Window state
  int unsigned base_q;
  int unsigned next_q;
  bit          acked [BUFFER_DEPTH];
  logic [31:0] stamp [BUFFER_DEPTH];
  logic [31:0] tick_q;
  logic [31:0] last_new_q;

  int unsigned errs;

  task automatic flag_error(input string msg);
    errs++;
    if (errs <= 10) $display("%s", msg);
  endtask

  // Work out the send beats caused by one input beat and queue them
  task automatic predict_sends(input logic cmd, input logic [SQ_W-1:0] seq,
                               input logic pos, input logic vld);
    send_beat_t  batch[$];
    send_beat_t  b;
    int unsigned w;
    int unsigned cnt;
    int unsigned i;
    w   = (win_r == 0) ? 1 : ((win_r > WINDOW_MAX) ? WINDOW_MAX : int'(win_r));
    cnt = (cnt_r > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(cnt_r);
    b   = '0;
    if (cmd == srsw_pkg::CMD_TICK) begin
      tick_q = tick_q + 32'd1;
      // timer scan across the sent part of the window
      for (i = base_q; i < base_q + w; i++) begin
        if (i >= next_q || i >= BUFFER_DEPTH) break;
        if (!acked[i] && (tick_q - stamp[i]) > tmo_r) begin
          stamp[i] = tick_q;
          b.seq    = SQ_W'(i);
          b.retx   = 1'b1;
          batch.push_back(b);
        end
      end
      // paced first send
      if ((tick_q - last_new_q) >= 32'(ivl_r) && next_q < base_q + w && next_q < cnt) begin
        stamp[next_q] = tick_q;
        b.seq         = SQ_W'(next_q);
        b.retx        = 1'b0;
        batch.push_back(b);
        next_q++;
        last_new_q = tick_q;
      end
    end else if (vld && seq >= base_q && seq < next_q && seq < BUFFER_DEPTH) begin
      if (pos) begin
        acked[seq] = 1'b1;
        while (base_q < next_q && base_q < BUFFER_DEPTH && acked[base_q]) begin
          acked[base_q] = 1'b0;
          base_q++;
        end
      end else if (!acked[seq]) begin
        b.seq  = seq;
        b.retx = 1'b1;
        batch.push_back(b);
      end
    end
    foreach (batch[k]) begin
      b      = batch[k];
      b.last = (k == batch.size() - 1);
      b.base = BS_W'(base_q);
      b.done = (base_q >= cnt);
      sends_due.push_back(b);
    end
  endtask

  always @(posedge clk) begin : track
    send_beat_t got;
    send_beat_t want;
    if (!rst_n) begin
      win_r      = srsw_pkg::RST_WINDOW_SIZE;
      cnt_r      = srsw_pkg::RST_PACKET_COUNT;
      tmo_r      = srsw_pkg::RST_TIMEOUT;
      ivl_r      = srsw_pkg::RST_SEND_INTERVAL;
      base_q     = 0;
      next_q     = 0;
      tick_q     = '0;
      last_new_q = '0;
      foreach (acked[j]) begin
        acked[j] = 1'b0;
        stamp[j] = '0;
      end
      sends_due.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          srsw_pkg::REG_WINDOW_SIZE:   win_r = cfg_pwdata[srsw_pkg::WIN_W-1:0];
          srsw_pkg::REG_PACKET_COUNT:  cnt_r = cfg_pwdata[srsw_pkg::PKT_CNT_W-1:0];
          srsw_pkg::REG_TIMEOUT:       tmo_r = cfg_pwdata[srsw_pkg::TIMEOUT_W-1:0];
          srsw_pkg::REG_SEND_INTERVAL: ivl_r = cfg_pwdata[srsw_pkg::INTERVAL_W-1:0];
          default: ;
        endcase
      end
      // output beat against oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.seq  = out_mon.send_seq;
        got.retx = out_mon.is_retransmit;
        got.last = out_mon.last;
        got.base = out_mon.window_base;
        got.done = out_mon.transfer_done;
        if (sends_due.size() == 0) begin
          flag_error($sformatf("unexpected send beat: seq %0d retx %0b last %0b base %0d done %0b",
                               got.seq, got.retx, got.last, got.base, got.done));
        end else begin
          want = sends_due.pop_front();
          if (got !== want)
            flag_error($sformatf({"send beat mismatch: expected seq %0d retx %0b last %0b",
                                  " base %0d done %0b, got seq %0d retx %0b last %0b",
                                  " base %0d done %0b"},
                                 want.seq, want.retx, want.last, want.base, want.done,
                                 got.seq, got.retx, got.last, got.base, got.done));
        end
      end
      // input beat
      if (in_mon.valid && in_mon.ready)
        predict_sends(in_mon.command, in_mon.ack_seq, in_mon.ack_positive, in_mon.ack_valid);
    end
    fail_count <= errs;
    pending    <= sends_due.size();
    model_base <= BS_W'(base_q);
    model_next <= BS_W'(next_q);
  end

endmodule

>>> verif/tb_selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window
// Drives ticks and acknowledgments into the sender window under several
// register settings, with random gaps on the input and random stalls on the
// output. A directed run covers the corner cases; random phases then mix
// ticks, in-window ACKs and NAKs with malformed acknowledgments. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 48;

  localparam int AD_W = srsw_pkg::CFG_ADDR_W;
  localparam int DA_W = srsw_pkg::CFG_DATA_W;
  localparam int SQ_W = srsw_pkg::SEQ_FIELD_W;
  localparam int BS_W = srsw_pkg::BASE_FIELD_W;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_psel;
  logic            cfg_penable;
  logic            cfg_pwrite;
  logic [AD_W-1:0] cfg_paddr;
  logic [DA_W-1:0] cfg_pwdata;
  logic [DA_W-1:0] cfg_prdata;
  logic            cfg_pready;

  int unsigned     chk_fails;
  int unsigned     chk_pending;
  logic [BS_W-1:0] model_base;
  logic [BS_W-1:0] model_next;

  logic        no_idle;
  int unsigned rdy_wait;
  int unsigned out_gap;
  int unsigned cycles = 0;

  srsw_in_if  in_if ();
  srsw_out_if out_if ();

  selective_repeat_sender_window DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  srsw_send_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (chk_fails),
    .pending     (chk_pending),
    .model_base  (model_base),
    .model_next  (model_next)
  );

  // Clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[selective_repeat_sender_window] ERROR");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Output side: random stall after each beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rdy_wait     <= 0;
    end else if (out_if.ready) begin
      if (out_if.valid) begin
        out_gap  = draw_gap();
        rdy_wait <= out_gap;
        if (out_gap != 0) out_if.ready <= 1'b0;
      end
    end else if (rdy_wait <= 1) begin
      out_if.ready <= 1'b1;
    end else begin
      rdy_wait <= rdy_wait - 1;
    end
  end

  // APB write: setup, access, then back to idle
  task automatic write_reg(input logic [1:0] idx, input logic [DA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned win, input int unsigned cnt,
                           input logic [31:0] tmo, input int unsigned ivl);
    write_reg(srsw_pkg::REG_WINDOW_SIZE, win);
    write_reg(srsw_pkg::REG_PACKET_COUNT, cnt);
    write_reg(srsw_pkg::REG_TIMEOUT, tmo);
    write_reg(srsw_pkg::REG_SEND_INTERVAL, ivl);
  endtask

  // One input beat, after a random gap
  task automatic drive_beat(input logic cmd, input logic [SQ_W-1:0] seq,
                            input logic pos, input logic vld);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.ack_seq      <= seq;
    in_if.ack_positive <= pos;
    in_if.ack_valid    <= vld;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Hold the input until every predicted beat has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  // Idle point for register writes
  task automatic settle();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic aimed at the live window, some noise
  task automatic random_beat();
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    lo = model_base;
    hi = model_next;
    r  = $urandom_range(0, 99);
    if (r < 45 || hi <= lo)
      drive_beat(srsw_pkg::CMD_TICK, SQ_W'($urandom), 1'($urandom), 1'($urandom));
    else if (r < 75)
      drive_beat(srsw_pkg::CMD_ACK, SQ_W'($urandom_range(lo, hi - 1)), 1'b1, 1'b1);
    else if (r < 85)
      drive_beat(srsw_pkg::CMD_ACK, SQ_W'($urandom_range(lo, hi - 1)), 1'b0, 1'b1);
    else if (r < 92)
      drive_beat(srsw_pkg::CMD_ACK, SQ_W'($urandom), 1'($urandom), 1'b0);
    else
      drive_beat(srsw_pkg::CMD_ACK, SQ_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(input int unsigned items, input bit hold);
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 12 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      if (hold && i == 15) drain();
      random_beat();
    end
  endtask

  function automatic int unsigned count_above(input int unsigned k);
    return (model_base + k > 256) ? 256 : model_base + k;
  endfunction

  initial begin
    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_if.valid        = 1'b0;
    in_if.command      = srsw_pkg::CMD_TICK;
    in_if.ack_seq      = '0;
    in_if.ack_positive = 1'b0;
    in_if.ack_valid    = 1'b0;
    no_idle            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill a small window, time out, ACK/NAK corners, finish
    configure(3, 6, 32'd2, 1);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_TICK, 8'd255, 1'b1, 1'b1);  // window full, timer expiry
    drive_beat(srsw_pkg::CMD_ACK, 8'd1, 1'b1, 1'b1);     // ACK above base, no slide
    drive_beat(srsw_pkg::CMD_ACK, 8'd0, 1'b1, 1'b0);     // failed integrity check
    drive_beat(srsw_pkg::CMD_ACK, 8'd7, 1'b1, 1'b1);     // not yet sent
    drive_beat(srsw_pkg::CMD_ACK, 8'd1, 1'b0, 1'b1);     // NAK on marked packet
    drive_beat(srsw_pkg::CMD_ACK, 8'd2, 1'b0, 1'b1);     // NAK re-send
    drive_beat(srsw_pkg::CMD_ACK, 8'd0, 1'b1, 1'b1);     // slide past 0 and 1
    drive_beat(srsw_pkg::CMD_ACK, 8'd0, 1'b0, 1'b1);     // below base
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_ACK, 8'd255, 1'b1, 1'b1);
    drive_beat(srsw_pkg::CMD_ACK, 8'd255, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_ACK, 8'd2, 1'b1, 1'b1);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_ACK, 8'd3, 1'b1, 1'b1);
    drive_beat(srsw_pkg::CMD_ACK, 8'd4, 1'b1, 1'b1);
    drive_beat(srsw_pkg::CMD_ACK, 8'd5, 1'b1, 1'b1);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    drive_beat(srsw_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0);
    settle();

    // Zero window acts as one
    configure(0, count_above(6), 32'd3, 1);
    run_phase(25, 1'b0);
    settle();

    // Oversized window, no timeouts, no pacing
    configure(63, 256, 32'hFFFF_FFFF, 0);
    run_phase(25, 1'b0);
    settle();

    // Aggressive timeouts, paced sends; one full drain mid-phase
    configure(8, count_above(20), 32'd1, 2);
    run_phase(30, 1'b1);
    settle();

    // Oversized count, zero timeout, no new sends
    configure(32, 511, 32'd0, 65535);
    run_phase(20, 1'b0);
    settle();

    // Short transfer run to completion
    configure(5, count_above(3), 32'd4, 3);
    run_phase(25, 1'b0);
    settle();

    // Count below base: re-sends report the transfer as done
    configure(16, 0, 32'd1, 1);
    run_phase(20, 1'b0);
    settle();

    if (chk_fails == 0 && chk_pending == 0)
      $display("[selective_repeat_sender_window] OK");
    else
      $display("[selective_repeat_sender_window] ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/srsw_pkg.sv
hdl/srsw_in_if.sv
hdl/srsw_out_if.sv
hdl/selective_repeat_sender_window.sv
verif/srsw_send_checker.sv
verif/tb_selective_repeat_sender_window.sv
